// ----- design/lfc_pkg.sv -----
// Package for the load force conditioner: word types, ring sizing and the
// fixed-point constants of the force, average and duty paths.
// No dependencies; used by the channel interfaces and the core.
package lfc_pkg;

	// Moving average length (power of two, so the mean is a shift)
	localparam int DEPTH      = 16;
	localparam int DEPTH_LOG2 = $clog2(DEPTH);

	localparam int LOAD_W  = 32;
	localparam int FORCE_W = 38;
	localparam int THR_W   = 37;
	localparam int DUTY_W  = 8;
	localparam int SUM_W   = FORCE_W + DEPTH_LOG2;
	localparam int DIFF_W  = FORCE_W + 1;

	typedef logic signed [LOAD_W-1:0]  load_t;
	typedef logic signed [FORCE_W-1:0] force_t;
	typedef logic        [THR_W-1:0]   thr_t;
	typedef logic        [DUTY_W-1:0]  duty_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic [DEPTH_LOG2-1:0]     ring_idx_t;

	// Grams/256 to micronewtons: (g * 9807) >>> 8
	localparam int            FPROD_W     = LOAD_W + 14;
	localparam int            FORCE_SHIFT = 8;
	localparam logic signed [FPROD_W-1:0] FORCE_MUL = 46'sd9807;

	localparam thr_t THR_RESET = 37'd500000;

	// Force over which duty saturates: 2000 cN = 20 N
	localparam longint CENTI_DIV = 10000;
	localparam longint DUTY_FULL = 2000;
	localparam thr_t   SAT_FORCE = 37'(CENTI_DIV * DUTY_FULL);

	// Below saturation force fits 25 bits; floor(f / 10000) by reciprocal
	localparam int     FLO_W    = 25;
	localparam int     CENTI_K  = 39;
	localparam int     CMUL_W   = 26;
	localparam int     CPROD_W  = FLO_W + CMUL_W;
	localparam int     CENTI_W  = 11;
	localparam longint CENTI_MUL_L = ((64'sd1 <<< CENTI_K) + CENTI_DIV - 1) / CENTI_DIV;
	localparam logic [CMUL_W-1:0] CENTI_MUL = CMUL_W'(CENTI_MUL_L);

	// floor(c * 255 / 2000) by reciprocal, c below 2000
	localparam int     SCALED_W = CENTI_W + 8;
	localparam int     DUTY_K   = 30;
	localparam int     DMUL_W   = 20;
	localparam int     DPROD_W  = SCALED_W + DMUL_W;
	localparam longint DUTY_MUL_L = ((64'sd1 <<< DUTY_K) + DUTY_FULL - 1) / DUTY_FULL;
	localparam logic [DMUL_W-1:0] DUTY_MUL = DMUL_W'(DUTY_MUL_L);
	localparam duty_t DUTY_MAX = 8'd255;

endpackage

// ----- design/lfc_if.sv -----
// Valid/ready channel interfaces of the load force conditioner: the sample
// word going in and the result word coming out. Depends on lfc_pkg.
interface lfc_load_if;
	import lfc_pkg::*;
	logic  valid;
	logic  ready;
	load_t load_grams;
	modport source (output valid, output load_grams, input ready);
	modport sink (input valid, input load_grams, output ready);
endinterface

interface lfc_result_if;
	import lfc_pkg::*;
	logic   valid;
	logic   ready;
	force_t force_un;
	force_t filtered_un;
	logic   contact;
	duty_t  pwm_duty;
	modport source (output valid, output force_un, output filtered_un, output contact,
		output pwm_duty, input ready);
	modport sink (input valid, input force_un, input filtered_un, input contact,
		input pwm_duty, output ready);
endinterface

// ----- design/load_force_conditioner_core.sv -----
// Load force conditioner core: force conversion, moving average, contact flag, PWM duty.
// Depends on lfc_pkg and the channel interfaces in lfc_if.sv.
//
// Usage:
//   load_in  : one signed load sample word (1/256 g) per valid/ready handshake.
//   force_out: one result word per sample: force (uN), mean of the last
//              DEPTH forces, contact flag and an 8-bit PWM duty.
//   cfg_we/cfg_wdata: writes the contact threshold (uN); change it only while
//              no sample is in flight.
// Throughput: one sample per cycle unless force_out stalls; the four-stage
//   pipeline (input register, force multiply, ring update with reciprocal
//   divide, accumulate and duty scale) advances as one.
// Stall: while a result waits on force_out, the whole pipeline holds and
//   load_in.ready drops; it follows force_out.ready in the same cycle.
// Reset: clears the ring, running sum and pointer (early means include the
//   zeros) and loads the threshold with 500000 uN.
module load_force_conditioner_core (
	input  logic                clk,
	input  logic                arst_n,
	lfc_load_if.sink            load_in,
	lfc_result_if.source        force_out,
	input  logic                cfg_we,
	input  lfc_pkg::thr_t       cfg_wdata
);
	import lfc_pkg::*;

	logic adv;

	// stage 1
	logic  v_s1;
	load_t load_s1;

	// stage 2
	logic               v_s2;
	force_t             force_s2;
	logic signed [FPROD_W-1:0] fprod;

	// stage 3
	logic                v_s3;
	force_t              force_s3;
	diff_t               diff_s3;
	logic                contact_s3;
	logic                neg_s3;
	logic                sat_s3;
	logic [CENTI_W-1:0]  centi_s3;
	logic [CPROD_W-1:0]  cprod;
	force_t              ring_old;

	// stage 4 (output)
	logic                v_s4;
	force_t              force_s4;
	force_t              filtered_s4;
	logic                contact_s4;
	duty_t               duty_s4;
	sum_t                sum_nxt;
	logic [SCALED_W-1:0] scaled;
	logic [DPROD_W-1:0]  dprod;

	// state
	force_t    force_ring_q [DEPTH];
	ring_idx_t ring_idx_q;
	sum_t      sum_q;
	thr_t      thr_q;

	// Pipeline moves whenever the output word is empty or being taken
	assign adv           = !v_s4 || force_out.ready;
	assign load_in.ready = adv;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= load_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: input register
	always_ff @(posedge clk) begin
		if (adv && load_in.valid) begin
			load_s1 <= load_in.load_grams;
		end
	end

	// Stage 2: force = floor(g * 9807 / 256)
	assign fprod = $signed({{(FPROD_W-LOAD_W){load_s1[LOAD_W-1]}}, load_s1}) * FORCE_MUL;

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			force_s2 <= fprod[FORCE_SHIFT +: FORCE_W];
		end
	end

	// Stage 3: ring swap, contact compare, centinewtons by reciprocal
	assign ring_old = force_ring_q[ring_idx_q];
	assign cprod    = CPROD_W'(force_s2[FLO_W-1:0]) * CPROD_W'(CENTI_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				force_ring_q[i] <= '0;
			end
			ring_idx_q <= '0;
		end else if (adv && v_s2) begin
			force_ring_q[ring_idx_q] <= force_s2;
			if (ring_idx_q == ring_idx_t'(DEPTH - 1)) begin
				ring_idx_q <= '0;
			end else begin
				ring_idx_q <= ring_idx_q + ring_idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			force_s3   <= force_s2;
			diff_s3    <= DIFF_W'(force_s2) - DIFF_W'(ring_old);
			contact_s3 <= !force_s2[FORCE_W-1] && (force_s2[THR_W-1:0] > thr_q);
			neg_s3     <= force_s2[FORCE_W-1];
			sat_s3     <= !force_s2[FORCE_W-1] && (force_s2[THR_W-1:0] >= SAT_FORCE);
			centi_s3   <= cprod[CENTI_K +: CENTI_W];
		end
	end

	// Stage 4: running sum, floored mean, duty scale and clamp
	assign sum_nxt = sum_q + SUM_W'(diff_s3);
	assign scaled  = {centi_s3, 8'd0} - SCALED_W'(centi_s3);
	assign dprod   = DPROD_W'(scaled) * DPROD_W'(DUTY_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv && v_s3) begin
			sum_q <= sum_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			force_s4    <= force_s3;
			filtered_s4 <= sum_nxt[DEPTH_LOG2 +: FORCE_W];
			contact_s4  <= contact_s3;
			if (neg_s3) begin
				duty_s4 <= '0;
			end else if (sat_s3) begin
				duty_s4 <= DUTY_MAX;
			end else begin
				duty_s4 <= dprod[DUTY_K +: DUTY_W];
			end
		end
	end

	// Result word
	assign force_out.valid       = v_s4;
	assign force_out.force_un    = force_s4;
	assign force_out.filtered_un = filtered_s4;
	assign force_out.contact     = contact_s4;
	assign force_out.pwm_duty    = duty_s4;

endmodule

// ----- dv/testbench.sv -----
// Testbench for load_force_conditioner_core: a directed table of samples and threshold
// writes, then random phases, all checked word by word against typed expectations or an in-bench predictor.
// Depends on lfc_pkg, lfc_if.sv and the core RTL.
module testbench;
	import lfc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     RESET_CYCLES   = 9;
	localparam int     PIPE_LATENCY   = 4;
	localparam int     STALL_LIMIT    = 1000;
	localparam int     PHASES         = 7;
	localparam int     PHASE_ITEMS    = 200;
	localparam longint UN_SCALE       = 9807;
	localparam longint LOAD_MIN       = -64'sd2147483648;
	localparam longint LOAD_MAX       = 64'sd2147483647;
	localparam longint THR_MAX        = 64'sd137438953471;

	typedef enum logic {ROW_SAMPLE, ROW_THRESHOLD} row_kind_e;

	typedef struct packed {
		force_t force_un;
		force_t filtered_un;
		logic   contact;
		duty_t  pwm_duty;
	} reading_t;

	typedef struct packed {
		row_kind_e kind;
		longint    value;
		logic      typed;
		reading_t  want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	thr_t cfg_wdata;

	lfc_load_if   load_ch();
	lfc_result_if res_ch();

	load_force_conditioner_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_in   (load_ch),
		.force_out (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor state: ring of forces, write pointer, running total, threshold
	longint   force_hist [DEPTH];
	int       hist_pos;
	longint   hist_total;
	thr_t     thr_model;

	reading_t pending_readings [$];
	int       fail_count;
	int       stall_cycles;
	int       samples_sent;
	int       words_checked;
	int       thr_writes;
	bit       tx_gaps_on;
	bit       rx_gaps_on;

	// Directed rows: typed expectations only where they are obvious
	stim_row_t directed_rows [25] = '{
		'{ROW_SAMPLE, 64'sd0, 1'b1, '{38'sd0, 38'sd0, 1'b0, 8'd0}},
		'{ROW_SAMPLE, LOAD_MIN, 1'b1,
			'{-38'sd82267078656, -38'sd5141692416, 1'b0, 8'd0}},
		'{ROW_SAMPLE, LOAD_MAX, 1'b1, '{38'sd82267078617, -38'sd3, 1'b1, 8'd255}},
		'{ROW_SAMPLE, 64'sd1, 1'b0, '0},
		'{ROW_SAMPLE, -64'sd1, 1'b0, '0},
		'{ROW_SAMPLE, 64'sd256, 1'b0, '0},
		'{ROW_SAMPLE, -64'sd256, 1'b0, '0},
		'{ROW_SAMPLE, 64'sd2085, 1'b0, '0},
		'{ROW_SAMPLE, 64'sd2089, 1'b0, '0},
		'{ROW_SAMPLE, 64'sd13052, 1'b0, '0},
		'{ROW_SAMPLE, 64'sd13051, 1'b0, '0},
		'{ROW_SAMPLE, 64'sd522000, 1'b0, '0},
		'{ROW_SAMPLE, 64'sd522100, 1'b0, '0},
		'{ROW_SAMPLE, 64'sd600000, 1'b0, '0},
		'{ROW_THRESHOLD, 64'sd0, 1'b0, '0},
		'{ROW_SAMPLE, 64'sd1, 1'b0, '0},
		'{ROW_SAMPLE, 64'sd0, 1'b0, '0},
		'{ROW_THRESHOLD, THR_MAX, 1'b0, '0},
		'{ROW_SAMPLE, LOAD_MAX, 1'b0, '0},
		// force of 13052 is exactly 500003 uN: equal means no contact
		'{ROW_THRESHOLD, 64'sd500003, 1'b0, '0},
		'{ROW_SAMPLE, 64'sd13052, 1'b0, '0},
		'{ROW_THRESHOLD, 64'sd500002, 1'b0, '0},
		'{ROW_SAMPLE, 64'sd13052, 1'b0, '0},
		'{ROW_THRESHOLD, 64'sd500000, 1'b0, '0},
		'{ROW_SAMPLE, LOAD_MIN, 1'b0, '0}
	};

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Force, moving mean, contact and duty for one sample; advances the ring
	function automatic reading_t condition_sample(load_t grams);
		longint   force_v;
		longint   mean_v;
		longint   centi;
		longint   duty;
		reading_t r;
		force_v = (longint'(grams) * UN_SCALE) >>> 8;
		hist_total = hist_total - force_hist[hist_pos] + force_v;
		force_hist[hist_pos] = force_v;
		hist_pos = (hist_pos + 1) % DEPTH;
		// DEPTH is a power of two, so the floored mean is an arithmetic shift
		mean_v = hist_total >>> DEPTH_LOG2;
		centi = force_v / CENTI_DIV;
		if (centi <= 0) begin
			duty = 0;
		end else begin
			duty = centi * 255 / DUTY_FULL;
			if (duty > 255)
				duty = 255;
		end
		r.force_un    = force_t'(force_v);
		r.filtered_un = force_t'(mean_v);
		r.contact     = (force_v >= 0) && (force_v > longint'(thr_model));
		r.pwm_duty    = duty_t'(duty);
		return r;
	endfunction

	// Gap length: mostly none, some short, a few long
	function automatic int pick_gap(bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Random sample: wide, around the duty range, near the threshold, extremes, small around zero
	function automatic load_t pick_load();
		int     r;
		longint g;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			g = longint'(int'($urandom));
		end else if (r < 70) begin
			g = longint'($urandom_range(0, 1200000)) - 600000;
		end else if (r < 85) begin
			g = longint'(thr_model) * 256 / UN_SCALE + $urandom_range(0, 8) - 4;
			if (g > LOAD_MAX)
				g = LOAD_MAX - $urandom_range(0, 3);
		end else if (r < 93) begin
			case ($urandom_range(0, 4))
				0: g = LOAD_MIN;
				1: g = LOAD_MAX;
				2: g = 0;
				3: g = -1;
				default: g = 1;
			endcase
		end else begin
			g = longint'($urandom_range(0, 65535)) - 32768;
		end
		return load_t'(g);
	endfunction

	// Offer one sample word, wait for it to be taken, then record its expectation
	task automatic send_word(load_t grams, logic typed, reading_t want);
		int       gap;
		reading_t predicted;
		gap = pick_gap(tx_gaps_on);
		@(negedge clk);
		if (gap > 0) begin
			load_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		load_ch.valid      <= 1'b1;
		load_ch.load_grams <= grams;
		do @(posedge clk); while (!(load_ch.valid && load_ch.ready));
		predicted = condition_sample(grams);
		pending_readings.push_back(typed ? want : predicted);
		samples_sent++;
	endtask

	// Drop valid and let every outstanding word come out
	task automatic drain_pipe();
		@(negedge clk);
		load_ch.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	// Threshold write, only with the pipeline empty
	task automatic write_threshold(thr_t thr);
		drain_pipe();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= thr;
		@(negedge clk);
		cfg_we    <= 1'b0;
		thr_model = thr;
		thr_writes++;
	endtask

	// Result side ready with random stalls
	initial begin
		int stall_left;
		stall_left   = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
				stall_left = pick_gap(rx_gaps_on);
			end
		end
	end

	// Check each accepted result word against the oldest expectation
	always @(posedge clk) begin
		reading_t want;
		if ((load_ch.valid && load_ch.ready) || (res_ch.valid && res_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_readings.size() == 0) begin
				$error("result word with no sample outstanding: force_un %0d",
					res_ch.force_un);
				fail_count++;
			end else begin
				want = pending_readings.pop_front();
				words_checked++;
				if (res_ch.force_un !== want.force_un) begin
					$error("force_un: expected %0d, got %0d", want.force_un, res_ch.force_un);
					fail_count++;
				end
				if (res_ch.filtered_un !== want.filtered_un) begin
					$error("filtered_un: expected %0d, got %0d", want.filtered_un,
						res_ch.filtered_un);
					fail_count++;
				end
				if (res_ch.contact !== want.contact) begin
					$error("contact: expected %0d, got %0d", want.contact, res_ch.contact);
					fail_count++;
				end
				if (res_ch.pwm_duty !== want.pwm_duty) begin
					$error("pwm_duty: expected %0d, got %0d", want.pwm_duty, res_ch.pwm_duty);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: nothing moving on either channel for too long
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// Main sequence
	initial begin
		int    burst_left;
		load_t burst_val;
		thr_t  thr;
		fail_count         = 0;
		stall_cycles       = 0;
		samples_sent       = 0;
		words_checked      = 0;
		thr_writes         = 0;
		burst_left         = 0;
		burst_val          = '0;
		tx_gaps_on         = 1'b1;
		rx_gaps_on         = 1'b1;
		hist_pos           = 0;
		hist_total         = 0;
		thr_model          = THR_RESET;
		foreach (force_hist[i])
			force_hist[i] = 0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		load_ch.valid      = 1'b0;
		load_ch.load_grams = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_THRESHOLD)
				write_threshold(thr_t'(directed_rows[i].value));
			else
				send_word(load_t'(directed_rows[i].value), directed_rows[i].typed,
					directed_rows[i].want);
		end

		// Random phases, each under its own threshold and idling mode
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: thr = THR_RESET;
				1: thr = '0;
				2: thr = thr_t'(THR_MAX);
				default: begin
					if ($urandom_range(0, 1) == 0)
						thr = thr_t'($urandom_range(0, 30000000));
					else
						thr = thr_t'({$urandom_range(0, 31), $urandom});
				end
			endcase
			write_threshold(thr);
			tx_gaps_on = (ph == 0) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
			rx_gaps_on = (ph == 0) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Occasional runs of one extreme fill the ring and push the sum to its limits
				if (burst_left == 0 && $urandom_range(0, 99) < 2) begin
					burst_left = $urandom_range(16, 24);
					burst_val  = ($urandom_range(0, 1) == 0) ? load_t'(LOAD_MIN)
						: load_t'(LOAD_MAX);
				end
				if (burst_left > 0) begin
					burst_left--;
					send_word(burst_val, 1'b0, '0);
				end else begin
					send_word(pick_load(), 1'b0, '0);
				end
			end
		end

		drain_pipe();
		repeat (PIPE_LATENCY + 8) @(posedge clk);

		$display("Sent %0d load samples, checked %0d result words under %0d threshold writes",
			samples_sent, words_checked, thr_writes);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
